@@ src/sbrfp_pkg.sv @@
`default_nettype none

package sbrfp_pkg;

    // Longest legal frame length byte (command plus parameters plus one).
    localparam int MAX_LENGTH = 8;
    localparam int NUM_PARAMS = 6;
    localparam int IDX_W      = 4;
    localparam int TDATA_W    = 80;

    // Limits on the length byte, at the width of a received byte.
    localparam logic [7:0] LEN_MIN = 8'd2;
    localparam logic [7:0] LEN_MAX = 8'(MAX_LENGTH);

    // Reset value of the expected length.
    localparam logic [IDX_W-1:0] EXP_RESET = 4'd2;

    // Byte positions inside a frame; the headers sit at positions 0 and 1.
    localparam logic [IDX_W-1:0] POS_IDLE   = 4'd0;
    localparam logic [IDX_W-1:0] POS_LENGTH = 4'd2;
    localparam logic [IDX_W-1:0] POS_CMD    = 4'd3;
    localparam logic [IDX_W-1:0] POS_PARAM0 = 4'd4;

    // Configuration register indexes.
    localparam logic [7:0] REG_HEADER_BYTE     = 8'd0;
    localparam logic [7:0] REG_BATTERY_COMMAND = 8'd1;

    localparam logic [7:0] HEADER_RESET  = 8'd85;
    localparam logic [7:0] BATTERY_RESET = 8'd15;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] battery_command;
    } t_config;

    typedef struct packed {
        logic [15:0]                battery_volt;
        logic [NUM_PARAMS-1:0][7:0] params;
        logic [IDX_W-1:0]           frame_length;
        logic [7:0]                 command;
        logic                       battery_valid;
    } t_result;

endpackage

`default_nettype wire

@@ src/servo_board_reply_frame_parser_unit.sv @@
// Reply frame parser: takes one received serial byte per word on the slave stream and
// reports each complete frame (two header bytes, a length byte of 2 to 8, a command
// byte and length-2 parameter bytes) as one word on the master stream. A byte enters
// the input register and is parsed from there straight into the result register,
// which feeds the master stream. One byte is taken every cycle while nothing
// stalls; the only stall comes from the result register when the master side holds
// tready low. A bad length byte drops the frame and the header search restarts with
// the following byte. Parameters past the frame's length read as zero, and
// battery_volt is zero unless battery_valid is set. The header byte and battery
// command are written over the configuration channel; the user must write them only
// while the block is idle; the block does not enforce it. Other indexes are ignored.
`default_nettype none

module servo_board_reply_frame_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // command, frame_length, param0..param5, battery_volt, zero fill
    output logic [sbrfp_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]       m_axis_tuser,   // battery_valid
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    import sbrfp_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       advance;
    logic       res_valid;
    t_result    result;
    t_result    out_result;
    t_config    r_cfg;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte     <= HEADER_RESET;
            r_cfg.battery_command <= BATTERY_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_HEADER_BYTE) begin
                r_cfg.header_byte <= i_cfg_data;
            end else if (i_cfg_index == REG_BATTERY_COMMAND) begin
                r_cfg.battery_command <= i_cfg_data;
            end
        end
    end

    sbrfp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    sbrfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_valid && advance),
        .i_byte      (in_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    sbrfp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_result    (result),
        .o_advance   (advance),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (out_result)
    );

    // Pack the result word, first field in the lowest bits.
    assign m_axis_tdata = {4'd0, out_result.battery_volt, out_result.params,
                           out_result.frame_length, out_result.command};
    assign m_axis_tuser = out_result.battery_valid;

endmodule

`default_nettype wire

@@ src/sbrfp_in_stage.sv @@
`default_nettype none

module sbrfp_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_advance,
    output logic            o_valid,
    output logic [7:0]      o_byte
);
    import sbrfp_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    // The register takes a new word whenever it is empty or drains this cycle.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

@@ src/sbrfp_parser.sv @@
`default_nettype none

module sbrfp_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [7:0]        i_byte,
    input  wire sbrfp_pkg::t_config i_cfg,
    output logic                   o_res_valid,
    output sbrfp_pkg::t_result     o_result
);
    import sbrfp_pkg::*;

    logic                       r_in_frame;
    logic                       r_hits;
    logic [IDX_W-1:0]           r_exp;
    logic [IDX_W-1:0]           r_idx;
    logic [7:0]                 r_cmd;
    logic [NUM_PARAMS-1:0][7:0] r_param;

    logic                       n_in_frame;
    logic                       n_hits;
    logic [IDX_W-1:0]           n_exp;
    logic [IDX_W-1:0]           n_idx;
    logic                       last_byte;
    logic [7:0]                 cmd_now;
    logic [NUM_PARAMS-1:0][7:0] par_now;

    // The frame ends on the byte at position length plus one.
    assign last_byte = r_in_frame && (r_idx != POS_LENGTH) && (r_idx == r_exp + 4'd1);

    // Header hunt, length check and position tracking.
    always_comb begin
        n_in_frame = r_in_frame;
        n_hits     = r_hits;
        n_exp      = r_exp;
        n_idx      = r_idx;
        if (i_fire) begin
            if (!r_in_frame) begin
                if (i_byte == i_cfg.header_byte) begin
                    if (r_hits) begin
                        n_in_frame = 1'b1;
                        n_hits     = 1'b0;
                        n_idx      = POS_LENGTH;
                    end else begin
                        n_hits = 1'b1;
                    end
                end else begin
                    n_hits = 1'b0;
                end
            end else if (r_idx == POS_LENGTH) begin
                if (i_byte < LEN_MIN || i_byte > LEN_MAX) begin
                    n_in_frame = 1'b0;
                    n_exp      = EXP_RESET;
                    n_idx      = POS_IDLE;
                end else begin
                    n_exp = i_byte[IDX_W-1:0];
                    n_idx = POS_CMD;
                end
            end else if (last_byte) begin
                n_in_frame = 1'b0;
                n_idx      = POS_IDLE;
            end else begin
                n_idx = r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_hits     <= 1'b0;
            r_exp      <= EXP_RESET;
            r_idx      <= POS_IDLE;
        end else begin
            r_in_frame <= n_in_frame;
            r_hits     <= n_hits;
            r_exp      <= n_exp;
            r_idx      <= n_idx;
        end
    end

    // Frame body store: command and parameter bytes by position.
    always_ff @(posedge i_clk) begin
        if (i_fire && r_in_frame) begin
            if (r_idx == POS_CMD) begin
                r_cmd <= i_byte;
            end
            for (int i = 0; i < NUM_PARAMS; i++) begin
                if (r_idx == POS_PARAM0 + IDX_W'(i)) begin
                    r_param[i] <= i_byte;
                end
            end
        end
    end

    // The last byte of a frame bypasses the store into the result.
    always_comb begin
        cmd_now = (r_idx == POS_CMD) ? i_byte : r_cmd;
        for (int i = 0; i < NUM_PARAMS; i++) begin
            if (IDX_W'(i) + 4'd2 < r_exp) begin
                par_now[i] = (r_idx == POS_PARAM0 + IDX_W'(i)) ? i_byte : r_param[i];
            end else begin
                par_now[i] = 8'd0;
            end
        end
    end

    always_comb begin
        o_res_valid            = i_fire && last_byte;
        o_result.command       = cmd_now;
        o_result.frame_length  = r_exp;
        o_result.params        = par_now;
        o_result.battery_valid = (cmd_now == i_cfg.battery_command);
        o_result.battery_volt  = o_result.battery_valid ? {par_now[1], par_now[0]} : 16'd0;
    end

endmodule

`default_nettype wire

@@ src/sbrfp_out_stage.sv @@
`default_nettype none

module sbrfp_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_res_valid,
    input  wire sbrfp_pkg::t_result i_result,
    output logic                    o_advance,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output sbrfp_pkg::t_result      o_result
);
    import sbrfp_pkg::*;

    logic    r_valid;
    t_result r_result;

    // The pipeline moves whenever the result register is free or being read.
    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ src/sbrfp_checker.sv @@
`default_nettype none

module sbrfp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [79:0] m_axis_tdata,
    input  wire logic [0:0]  m_axis_tuser
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // Reported lengths are always legal.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11:8] >= 4'd2 && m_axis_tdata[11:8] <= 4'd8))
        else $error("illegal frame length reported");

    // Voltage is the first two parameters for a battery reply and zero otherwise.
    a_volt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0]
            ? m_axis_tdata[75:60] == {m_axis_tdata[27:20], m_axis_tdata[19:12]}
            : m_axis_tdata[75:60] == 16'd0))
        else $error("battery voltage mismatch");

    // A frame without parameters reports all parameters as zero.
    a_nopar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[11:8] == 4'd2 |-> m_axis_tdata[59:12] == 48'd0)
        else $error("absent parameters not zero");

endmodule

bind servo_board_reply_frame_parser_unit sbrfp_checker u_sbrfp_checker (.*);

`default_nettype wire
